/* rtl/awu_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// awu_pkg
// Shared constants for the AdamW parameter update unit.
// ---------------------------------------------------------------------------
package awu_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BETA_W     = 25;
  localparam int unsigned SLOT_W     = 9;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned M_W        = 32;
  localparam int unsigned V_W        = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_SECOND = 3'd6;

  localparam logic [BETA_W-1:0] ONE_Q24 = 25'h100_0000;

  localparam logic [BETA_W-1:0] BETA_FIRST_RST  = 25'd15267021;
  localparam logic [BETA_W-1:0] BETA_SECOND_RST = 25'd15468593;
  localparam logic [31:0] STEP_RATE_RST   = 32'd128849019;
  localparam logic [31:0] DECAY_RATE_RST  = 32'd21475;
  localparam logic [31:0] DEN_FLOOR_RST   = 32'd429;
  localparam logic [31:0] CORR_FIRST_RST  = 32'd728178;
  localparam logic [31:0] CORR_SECOND_RST = 32'd840205;

  typedef logic signed [40:0] mul_a_t;
  typedef logic signed [32:0] mul_b_t;
  typedef logic signed [73:0] mul_p_t;

endpackage
`default_nettype wire

/* rtl/awu_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// awu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module awu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/adamw_parameter_update_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// adamw_parameter_update_unit
// AdamW moment update and delta computation in fixed point, one request
// at a time, with per-slot moments held in two RAMs.
// ---------------------------------------------------------------------------
// After reset the unit zeroes the moment RAMs and holds in_stall high
// meanwhile; configuration writes are taken throughout.
// Each request then passes through these steps in order: idle to take it,
// the slot reduction, the RAM read, moment update and products on one shared
// 41x33 multiplier, the bit-serial square root, forming the denominator, the
// bit-serial divider that forms lr*m_hat/(sqrt(v_hat)+eps) and loading the
// output register, which waits while a result already held there is stalled.
// A new request is taken as soon as the previous one has been placed in the
// output register.
// ---------------------------------------------------------------------------
module adamw_parameter_update_unit #(
  parameter int unsigned SLOT_COUNT = 512
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we,
  input  wire logic [awu_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [awu_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [awu_pkg::SLOT_W-1:0]              in_param_slot,
  input  wire logic signed [awu_pkg::VAL_W-1:0]        in_gradient,
  input  wire logic signed [awu_pkg::VAL_W-1:0]        in_param_value,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [awu_pkg::SLOT_W-1:0]                   out_slot_echo,
  output logic signed [awu_pkg::VAL_W-1:0]             out_update_delta,
  output logic                                         out_saturated
);

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [9:0] SLOT_CMP = 10'((SLOT_COUNT < 512) ? SLOT_COUNT : 512);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_MODS  = 5'd2;
  localparam logic [4:0] ST_RD    = 5'd3;
  localparam logic [4:0] ST_M1    = 5'd4;
  localparam logic [4:0] ST_M2    = 5'd5;
  localparam logic [4:0] ST_M3    = 5'd6;
  localparam logic [4:0] ST_M4    = 5'd7;
  localparam logic [4:0] ST_M5    = 5'd8;
  localparam logic [4:0] ST_M6    = 5'd9;
  localparam logic [4:0] ST_M7    = 5'd10;
  localparam logic [4:0] ST_M8    = 5'd11;
  localparam logic [4:0] ST_M9    = 5'd12;
  localparam logic [4:0] ST_M10   = 5'd13;
  localparam logic [4:0] ST_SQRT  = 5'd14;
  localparam logic [4:0] ST_DFORM = 5'd15;
  localparam logic [4:0] ST_DIV   = 5'd16;
  localparam logic [4:0] ST_FIN   = 5'd17;

  // configuration
  logic [awu_pkg::BETA_W-1:0] beta1_r, beta2_r;
  logic [31:0] lr_r, wd_r, eps_r, cf_r, cs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta1_r <= awu_pkg::BETA_FIRST_RST;
      beta2_r <= awu_pkg::BETA_SECOND_RST;
      lr_r    <= awu_pkg::STEP_RATE_RST;
      wd_r    <= awu_pkg::DECAY_RATE_RST;
      eps_r   <= awu_pkg::DEN_FLOOR_RST;
      cf_r    <= awu_pkg::CORR_FIRST_RST;
      cs_r    <= awu_pkg::CORR_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awu_pkg::CFG_BETA_FIRST:  beta1_r <= cfg_wdata[awu_pkg::BETA_W-1:0];
        awu_pkg::CFG_BETA_SECOND: beta2_r <= cfg_wdata[awu_pkg::BETA_W-1:0];
        awu_pkg::CFG_STEP_RATE:   lr_r    <= cfg_wdata;
        awu_pkg::CFG_DECAY_RATE:  wd_r    <= cfg_wdata;
        awu_pkg::CFG_DEN_FLOOR:   eps_r   <= cfg_wdata;
        awu_pkg::CFG_CORR_FIRST:  cf_r    <= cfg_wdata;
        awu_pkg::CFG_CORR_SECOND: cs_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic [awu_pkg::BETA_W-1:0] b1, b2, b1c, b2c;
  assign b1  = (beta1_r > awu_pkg::ONE_Q24) ? awu_pkg::ONE_Q24 : beta1_r;
  assign b2  = (beta2_r > awu_pkg::ONE_Q24) ? awu_pkg::ONE_Q24 : beta2_r;
  assign b1c = awu_pkg::ONE_Q24 - b1;
  assign b2c = awu_pkg::ONE_Q24 - b2;

  // control and datapath registers
  logic [4:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [8:0] slot_r, sh_r;
  logic [9:0] mod_r;
  logic signed [31:0] g_r, w_r, m_r, k_r;
  logic [38:0] g2_r;
  logic [39:0] v_r;
  logic signed [73:0] acc_r;
  logic signed [47:0] mhat_r;
  logic [47:0] mag_r;
  logic [55:0] pl_r;
  logic [79:0] num_r;
  logic [63:0] x_r;
  logic [35:0] srem_r;
  logic [31:0] root_r;
  logic [40:0] d_r;
  logic [41:0] drem_r;
  logic [34:0] quo_r;
  logic qsat_r, clip_r;

  logic out_valid_r;
  logic [8:0] out_slot_r;
  logic signed [31:0] out_delta_r;
  logic out_sat_r;

  // RAMs
  logic m_we, v_we, rd_en;
  logic [AW-1:0] waddr, idx;
  logic [31:0] m_wdata, m_rdata;
  logic [39:0] v_wdata, v_rdata;

  assign idx = AW'(mod_r);

  awu_ram #(.WIDTH(awu_pkg::M_W), .DEPTH(SLOT_COUNT)) u_first (
    .clk(clk), .we(m_we), .waddr(waddr), .wdata(m_wdata),
    .re(rd_en), .raddr(idx), .rdata(m_rdata)
  );

  awu_ram #(.WIDTH(awu_pkg::V_W), .DEPTH(SLOT_COUNT)) u_second (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wdata),
    .re(rd_en), .raddr(idx), .rdata(v_rdata)
  );

  always_comb begin
    rd_en   = (state_r == ST_RD);
    m_we    = (state_r == ST_CLR) || (state_r == ST_M6);
    v_we    = m_we;
    waddr   = (state_r == ST_CLR) ? clr_r : idx;
    m_wdata = (state_r == ST_CLR) ? 32'd0 : m_r;
    v_wdata = (state_r == ST_CLR) ? 40'd0 : v_r;
  end

  // shared multiplier
  awu_pkg::mul_a_t mul_a;
  awu_pkg::mul_b_t mul_b;
  awu_pkg::mul_p_t mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_M1: begin
        mul_a = 41'(signed'(m_rdata));
        mul_b = $signed({8'd0, b1});
      end
      ST_M2: begin
        mul_a = 41'(g_r);
        mul_b = $signed({8'd0, b1c});
      end
      ST_M3: begin
        mul_a = 41'(g_r);
        mul_b = 33'(g_r);
      end
      ST_M4: begin
        mul_a = $signed({1'b0, v_r});
        mul_b = $signed({8'd0, b2});
      end
      ST_M5: begin
        mul_a = $signed({2'b0, g2_r});
        mul_b = $signed({8'd0, b2c});
      end
      ST_M6: begin
        mul_a = 41'(m_r);
        mul_b = $signed({1'b0, cf_r});
      end
      ST_M7: begin
        mul_a = $signed({1'b0, v_r});
        mul_b = $signed({1'b0, cs_r});
      end
      ST_M8: begin
        mul_a = 41'(w_r);
        mul_b = $signed({1'b0, wd_r});
      end
      ST_M9: begin
        mul_a = $signed({17'd0, mag_r[23:0]});
        mul_b = $signed({1'b0, lr_r});
      end
      ST_M10: begin
        mul_a = $signed({17'd0, mag_r[47:24]});
        mul_b = $signed({1'b0, lr_r});
      end
      default: begin
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [73:0] acc_sum;
  assign acc_sum = acc_r + mul_p;

  logic clip_v;
  assign clip_v = |mul_p[73:56];

  // bit-serial steps
  logic [9:0]  mod_sh;
  logic [35:0] srem_sh, s_trial;
  logic [41:0] drem_sh;
  logic [34:0] quo_sh;
  logic        dbit;

  assign mod_sh  = {mod_r[8:0], sh_r[8]};
  assign srem_sh = {srem_r[33:0], x_r[63:62]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign drem_sh = {drem_r[40:0], num_r[79]};
  assign dbit    = (drem_sh >= {1'b0, d_r});
  assign quo_sh  = {quo_r[33:0], dbit};

  // final sum
  logic [33:0] q_mag;
  logic signed [34:0] q_s;
  logic signed [35:0] dsum;
  logic hi_clip, lo_clip;
  logic signed [31:0] delta;

  always_comb begin
    if (mag_r == 48'd0) begin
      q_mag = 34'd0;
    end else if (qsat_r) begin
      q_mag = 34'h2_0000_0000;
    end else begin
      q_mag = quo_r[33:0];
    end
    q_s     = mhat_r[47] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    dsum    = 36'(q_s) + 36'(k_r);
    hi_clip = (dsum > 36'sd2147483647);
    lo_clip = (dsum < -36'sd2147483648);
    priority if (hi_clip) begin
      delta = 32'sh7FFF_FFFF;
    end else if (lo_clip) begin
      delta = 32'sh8000_0000;
    end else begin
      delta = dsum[31:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_nxt = 7'd0;
        if (in_valid) begin
          state_nxt = ST_MODS;
        end
      end
      ST_MODS: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_M1;
      ST_M1:  state_nxt = ST_M2;
      ST_M2:  state_nxt = ST_M3;
      ST_M3:  state_nxt = ST_M4;
      ST_M4:  state_nxt = ST_M5;
      ST_M5:  state_nxt = ST_M6;
      ST_M6:  state_nxt = ST_M7;
      ST_M7:  state_nxt = ST_M8;
      ST_M8:  state_nxt = ST_M9;
      ST_M9:  state_nxt = ST_M10;
      ST_M10: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = 7'd0;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd31) begin
          state_nxt = ST_DFORM;
        end
      end
      ST_DFORM: begin
        state_nxt = ST_DIV;
        cnt_nxt   = 7'd0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        slot_r <= in_param_slot;
        sh_r   <= in_param_slot;
        g_r    <= in_gradient;
        w_r    <= in_param_value;
        mod_r  <= 10'd0;
      end
      ST_MODS: begin
        sh_r  <= {sh_r[7:0], 1'b0};
        mod_r <= (mod_sh >= SLOT_CMP) ? (mod_sh - SLOT_CMP) : mod_sh;
      end
      ST_M1: begin
        acc_r <= mul_p;
        v_r   <= v_rdata;
      end
      ST_M2: m_r  <= acc_sum[55:24];
      ST_M3: g2_r <= mul_p[62:24];
      ST_M4: acc_r <= mul_p;
      ST_M5: v_r  <= acc_sum[63:24];
      ST_M6: mhat_r <= mul_p[63:16];
      ST_M7: begin
        clip_r <= clip_v;
        x_r    <= {(clip_v ? 40'hFF_FFFF_FFFF : mul_p[55:16]), 24'd0};
        srem_r <= '0;
        root_r <= '0;
        mag_r  <= mhat_r[47] ? 48'(-mhat_r) : 48'(mhat_r);
      end
      ST_M8: k_r  <= mul_p[63:32];
      ST_M9: pl_r <= mul_p[55:0];
      ST_M10: num_r <= {mul_p[55:0], 24'd0} + {24'd0, pl_r};
      ST_SQRT: begin
        x_r <= {x_r[61:0], 2'b00};
        if (srem_sh >= s_trial) begin
          srem_r <= srem_sh - s_trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      ST_DFORM: begin
        d_r    <= {1'b0, root_r, 8'd0} + {9'd0, eps_r};
        drem_r <= '0;
        quo_r  <= '0;
        qsat_r <= 1'b0;
      end
      ST_DIV: begin
        num_r  <= {num_r[78:0], 1'b0};
        drem_r <= dbit ? (drem_sh - {1'b0, d_r}) : drem_sh;
        quo_r  <= quo_sh;
        qsat_r <= qsat_r | quo_sh[34] | quo_sh[33];
      end
      ST_FIN: begin
        if (out_free) begin
          out_slot_r  <= slot_r;
          out_delta_r <= delta;
          out_sat_r   <= clip_r | hi_clip | lo_clip;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_slot_echo    = out_slot_r;
  assign out_update_delta = out_delta_r;
  assign out_saturated    = out_sat_r;

endmodule
`default_nettype wire
